// ----- design/lfpc_pkg.sv -----
`default_nettype none

package lfpc_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 9;
    localparam int unsigned SEL_W      = 2;
    localparam int unsigned CFG_IDX_W  = 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGN_FRAME_ID = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIVE_ID      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIVE_IVAL    = 8'd3;

    // Reset values of the registers
    localparam logic [BYTE_W-1:0] RST_HEADER_BYTE   = 8'hff;
    localparam logic [BYTE_W-1:0] RST_SIGN_FRAME_ID = 8'hed;
    localparam logic [BYTE_W-1:0] RST_ALIVE_ID      = 8'h1c;
    localparam logic [BYTE_W-1:0] RST_ALIVE_IVAL    = 8'd100;

    // Text selector: starts at one, then runs two, three, two, three
    localparam logic [SEL_W-1:0] SEL_START = 2'd1;
    localparam logic [SEL_W-1:0] SEL_LOW   = 2'd2;
    localparam logic [SEL_W-1:0] SEL_HIGH  = 2'd3;

    // Byte positions within a frame
    localparam logic [POS_W-1:0] POS_ID      = 9'd1;
    localparam logic [POS_W-1:0] POS_LENGTH  = 9'd2;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] sign_frame_id;
        logic [BYTE_W-1:0] alive_frame_id;
        logic [BYTE_W-1:0] alive_log_interval;
    } cfg_t;

    typedef struct packed {
        logic              frame_ok;
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] payload_length;
        logic              sign_trigger;
        logic [SEL_W-1:0]  text_select;
        logic              alive_seen;
        logic              alive_milestone;
    } result_t;

endpackage

`default_nettype wire

// ----- design/lfpc_parser.sv -----
`default_nettype none

module lfpc_parser (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire lfpc_pkg::cfg_t   cfg,
    input  wire                   byte_valid,
    input  wire [7:0]             byte_data,
    input  wire                   byte_fire,
    output logic                  has_result,
    output lfpc_pkg::result_t     result
);
    import lfpc_pkg::*;

    logic              in_frame_reg,      in_frame_next;
    logic [POS_W-1:0]  byte_pos_reg,      byte_pos_next;
    logic [BYTE_W-1:0] held_id_reg,       held_id_next;
    logic [BYTE_W-1:0] held_length_reg,   held_length_next;
    logic [BYTE_W-1:0] running_sum_reg,   running_sum_next;
    logic [SEL_W-1:0]  text_sel_reg,      text_sel_next;
    logic [BYTE_W-1:0] alive_count_reg,   alive_count_next;

    logic              is_header;
    logic [POS_W-1:0]  checksum_pos;
    logic              sum_ok;
    logic [BYTE_W:0]   alive_inc;

    assign is_header    = (byte_data == cfg.header_byte);
    assign checksum_pos = {1'b0, held_length_reg} + POS_PAYLOAD;
    assign sum_ok       = (running_sum_reg == byte_data);
    assign alive_inc    = {1'b0, alive_count_reg} + {{BYTE_W{1'b0}}, 1'b1};

    always_comb
    begin
        in_frame_next    = in_frame_reg;
        byte_pos_next    = byte_pos_reg;
        held_id_next     = held_id_reg;
        held_length_next = held_length_reg;
        running_sum_next = running_sum_reg;
        text_sel_next    = text_sel_reg;
        alive_count_next = alive_count_reg;
        has_result       = 1'b0;
        result           = '0;

        priority if (is_header)
        begin
            in_frame_next    = 1'b1;
            byte_pos_next    = POS_ID;
            running_sum_next = '0;
        end
        else if (!in_frame_reg)
        begin
            // ignore bytes between frames
        end
        else if (byte_pos_reg == POS_ID)
        begin
            held_id_next  = byte_data;
            byte_pos_next = POS_LENGTH;
        end
        else if (byte_pos_reg == POS_LENGTH)
        begin
            held_length_next = byte_data;
            byte_pos_next    = POS_PAYLOAD;
        end
        else if (byte_pos_reg < checksum_pos)
        begin
            running_sum_next = running_sum_reg + byte_data;
            byte_pos_next    = byte_pos_reg + POS_ID;
        end
        else
        begin
            has_result            = 1'b1;
            result.frame_ok       = sum_ok;
            result.frame_id       = held_id_reg;
            result.payload_length = held_length_reg;
            if (sum_ok)
            begin
                priority if (held_id_reg == cfg.sign_frame_id)
                begin
                    text_sel_next       = (text_sel_reg == SEL_HIGH) ? SEL_LOW
                                                                     : text_sel_reg + 2'd1;
                    result.sign_trigger = 1'b1;
                end
                else if (held_id_reg == cfg.alive_frame_id)
                begin
                    result.alive_seen = 1'b1;
                    if (alive_inc >= {1'b0, cfg.alive_log_interval})
                    begin
                        alive_count_next       = '0;
                        result.alive_milestone = 1'b1;
                    end
                    else
                    begin
                        alive_count_next = alive_inc[BYTE_W-1:0];
                    end
                end
                else
                begin
                    // valid frame of another kind: report only
                end
            end
            result.text_select = text_sel_next;
            in_frame_next      = 1'b0;
            byte_pos_next      = '0;
            running_sum_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            byte_pos_reg    <= '0;
            held_id_reg     <= '0;
            held_length_reg <= '0;
            running_sum_reg <= '0;
            text_sel_reg    <= SEL_START;
            alive_count_reg <= '0;
        end
        else if (byte_valid && byte_fire)
        begin
            in_frame_reg    <= in_frame_next;
            byte_pos_reg    <= byte_pos_next;
            held_id_reg     <= held_id_next;
            held_length_reg <= held_length_next;
            running_sum_reg <= running_sum_next;
            text_sel_reg    <= text_sel_next;
            alive_count_reg <= alive_count_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/length_framed_packet_checker.sv -----
`default_nettype none

// Length-framed packet checker. Takes one received byte per request and
// parses frames of header, ID, payload length L, L payload bytes and an
// 8-bit additive checksum of the payload. A header byte always restarts the
// frame; bytes outside a frame are dropped. Each checksum byte yields one
// result request carrying the match flag, ID, length, the sign-text selector
// and the alive flags. A byte is taken every cycle unless the input stalls: it
// lands in an input register, passes the parser's combinational step logic
// and, if it ends a frame, lands in the result register. The input stalls
// only while a result waits at the output and the byte held in the input
// register would produce another one.
// Configuration writes are taken at any time but must only be made while
// the block is idle.

module length_framed_packet_checker (
    input  wire        clk,
    input  wire        rst_n,

    // configuration write port
    input  wire        cfg_write,
    input  wire [7:0]  cfg_index,
    input  wire [7:0]  cfg_data,

    // byte input
    input  wire        in_valid,
    output logic       in_stall,
    input  wire [7:0]  rx_byte,

    // result output
    output logic       out_valid,
    input  wire        out_stall,
    output logic       frame_ok,
    output logic [7:0] frame_id,
    output logic [7:0] payload_length,
    output logic       sign_trigger,
    output logic [1:0] text_select,
    output logic       alive_seen,
    output logic       alive_milestone
);
    import lfpc_pkg::*;

    cfg_t              cfg_reg;

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;

    logic              out_valid_reg;
    result_t           out_reg;

    logic              has_result;
    result_t           result;
    logic              out_free;
    logic              s1_fire;

    // Write the addressed register; indexes beyond the list change nothing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte        <= RST_HEADER_BYTE;
            cfg_reg.sign_frame_id      <= RST_SIGN_FRAME_ID;
            cfg_reg.alive_frame_id     <= RST_ALIVE_ID;
            cfg_reg.alive_log_interval <= RST_ALIVE_IVAL;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HEADER_BYTE:   cfg_reg.header_byte        <= cfg_data;
                CFG_SIGN_FRAME_ID: cfg_reg.sign_frame_id      <= cfg_data;
                CFG_ALIVE_ID:      cfg_reg.alive_frame_id     <= cfg_data;
                CFG_ALIVE_IVAL:    cfg_reg.alive_log_interval <= cfg_data;
                default:           ;
            endcase
        end
    end

    lfpc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_valid (s1_valid_reg),
        .byte_data  (s1_byte_reg),
        .byte_fire  (s1_fire),
        .has_result (has_result),
        .result     (result)
    );

    // The result register frees up when empty or when its request is taken.
    // A held byte advances unless it needs the result register and that is full.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && (!has_result || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // Hold a waiting result until taken; load a new one when the step yields it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_fire && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_fire && has_result)
        begin
            out_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_ok        = out_reg.frame_ok;
    assign frame_id        = out_reg.frame_id;
    assign payload_length  = out_reg.payload_length;
    assign sign_trigger    = out_reg.sign_trigger;
    assign text_select     = out_reg.text_select;
    assign alive_seen      = out_reg.alive_seen;
    assign alive_milestone = out_reg.alive_milestone;

endmodule

`default_nettype wire

// ----- test/tb_length_framed_packet_checker.sv -----
`timescale 1ns / 1ps

module tb_length_framed_packet_checker;

    import lfpc_pkg::*;

    // Clock period halves, settle time before a register write and the
    // length of the long output hold-off.
    localparam int HALF_PERIOD  = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD    = 200;
    localparam int PHASE_BYTES  = 270;

    // One row of the directed stimulus: a byte, and where the outcome is
    // obvious, the verdict typed in by hand.
    typedef struct {
        logic [BYTE_W-1:0] rx;
        bit                fixed;
        result_t           verdict;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write;
    logic [7:0]        cfg_index;
    logic [7:0]        cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              frame_ok;
    logic [7:0]        frame_id;
    logic [7:0]        payload_length;
    logic              sign_trigger;
    logic [1:0]        text_select;
    logic              alive_seen;
    logic              alive_milestone;

    // Frame parser copy used to work out each verdict
    cfg_t              parser_cfg;
    bit                parser_in_frame;
    logic [POS_W-1:0]  parser_pos;
    logic [BYTE_W-1:0] parser_id;
    logic [BYTE_W-1:0] parser_len;
    logic [BYTE_W-1:0] parser_sum;
    logic [SEL_W-1:0]  parser_sel;
    logic [BYTE_W-1:0] parser_alive_count;

    result_t           pending_verdicts[$];
    stim_row_t         directed_rows[$];
    int                mismatch_count = 0;
    int                sent_count     = 0;
    int                src_idle_pct   = 0;
    int                snk_idle_pct   = 0;
    int                holds_requested = 0;
    int                holds_served    = 0;
    int                hold_left       = 0;

    length_framed_packet_checker u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .frame_ok        (frame_ok),
        .frame_id        (frame_id),
        .payload_length  (payload_length),
        .sign_trigger    (sign_trigger),
        .text_select     (text_select),
        .alive_seen      (alive_seen),
        .alive_milestone (alive_milestone)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    // Return everything to its post-reset state, registers included.
    task automatic reset_parser();
        parser_cfg.header_byte        = RST_HEADER_BYTE;
        parser_cfg.sign_frame_id      = RST_SIGN_FRAME_ID;
        parser_cfg.alive_frame_id     = RST_ALIVE_ID;
        parser_cfg.alive_log_interval = RST_ALIVE_IVAL;
        parser_in_frame    = 1'b0;
        parser_pos         = '0;
        parser_id          = '0;
        parser_len         = '0;
        parser_sum         = '0;
        parser_sel         = SEL_START;
        parser_alive_count = '0;
    endtask

    // Advance the parser by one byte. Returns 1 when the byte closes a frame,
    // with the verdict in v.
    function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output result_t v);
        int next_count;
        v = '0;
        // a header byte restarts the frame wherever it turns up
        if (b == parser_cfg.header_byte)
        begin
            parser_in_frame = 1'b1;
            parser_pos      = POS_ID;
            parser_sum      = '0;
            return 1'b0;
        end
        // drop anything between frames
        if (!parser_in_frame)
            return 1'b0;
        if (parser_pos == POS_ID)
        begin
            parser_id  = b;
            parser_pos = POS_LENGTH;
            return 1'b0;
        end
        if (parser_pos == POS_LENGTH)
        begin
            parser_len = b;
            parser_pos = POS_PAYLOAD;
            return 1'b0;
        end
        if (int'(parser_pos) < int'(parser_len) + int'(POS_PAYLOAD))
        begin
            parser_sum = parser_sum + b;
            parser_pos = parser_pos + POS_W'(1);
            return 1'b0;
        end

        // checksum position
        v.frame_ok = (parser_sum == b);
        if (v.frame_ok)
        begin
            if (parser_id == parser_cfg.sign_frame_id)
            begin
                // one, two, three, then back and forth between two and three
                parser_sel     = (parser_sel == SEL_HIGH) ? SEL_LOW
                                                          : parser_sel + SEL_W'(1);
                v.sign_trigger = 1'b1;
            end
            else if (parser_id == parser_cfg.alive_frame_id)
            begin
                next_count   = int'(parser_alive_count) + 1;
                v.alive_seen = 1'b1;
                // a lowered interval fires as soon as the count is at or past it
                if (next_count >= int'(parser_cfg.alive_log_interval))
                begin
                    next_count        = 0;
                    v.alive_milestone = 1'b1;
                end
                parser_alive_count = next_count[BYTE_W-1:0];
            end
        end
        v.frame_id       = parser_id;
        v.payload_length = parser_len;
        v.text_select    = parser_sel;
        parser_in_frame  = 1'b0;
        parser_pos       = '0;
        parser_sum       = '0;
        return 1'b1;
    endfunction

    // Swap a byte that would restart the frame for a neighbouring value.
    function automatic logic [BYTE_W-1:0] avoid_header(input logic [BYTE_W-1:0] b);
        return (b == parser_cfg.header_byte) ? (b ^ 8'h01) : b;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Take each result request that leaves the block and hold it against the
    // oldest verdict waiting.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {frame_ok, frame_id, payload_length, sign_trigger, text_select,
                   alive_seen, alive_milestone};
            if (pending_verdicts.size() == 0)
                report_mismatch("result request with no verdict pending");
            else
            begin
                want = pending_verdicts.pop_front();
                compare_field("frame_ok", int'(got.frame_ok), int'(want.frame_ok));
                compare_field("frame_id", int'(got.frame_id), int'(want.frame_id));
                compare_field("payload_length", int'(got.payload_length),
                              int'(want.payload_length));
                compare_field("sign_trigger", int'(got.sign_trigger),
                              int'(want.sign_trigger));
                compare_field("text_select", int'(got.text_select), int'(want.text_select));
                compare_field("alive_seen", int'(got.alive_seen), int'(want.alive_seen));
                compare_field("alive_milestone", int'(got.alive_milestone),
                              int'(want.alive_milestone));
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stall, plus a long hold-off whenever the main
    // sequence asks for one. The hold is counted here so that the sender
    // keeps offering requests meanwhile and the block backs up.
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (holds_served != holds_requested)
        begin
            holds_served = holds_requested;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < snk_idle_pct);
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one byte, hold it until taken, then record the verdict it causes.
    // A typed-in verdict stands in for the predicted one on directed rows.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit fixed = 1'b0,
                             input result_t typed = '0);
        result_t predicted;
        bit      closes;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        closes = parse_byte(b, predicted);
        if (fixed)
            pending_verdicts.push_back(typed);
        else if (closes)
            pending_verdicts.push_back(predicted);
        sent_count++;
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Hold the sender until every verdict is in, then give the last byte time
    // to clear the pipeline even if it closed no frame.
    task automatic drain();
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic apply_settings(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] sign,
                                  input logic [BYTE_W-1:0] alive, input logic [BYTE_W-1:0] ival);
        write_reg(CFG_HEADER_BYTE, hdr);
        write_reg(CFG_SIGN_FRAME_ID, sign);
        write_reg(CFG_ALIVE_ID, alive);
        write_reg(CFG_ALIVE_IVAL, ival);
        @(negedge clk);
        cfg_write <= 1'b0;
        parser_cfg.header_byte        = hdr;
        parser_cfg.sign_frame_id      = sign;
        parser_cfg.alive_frame_id     = alive;
        parser_cfg.alive_log_interval = ival;
    endtask

    // One random frame, mostly well formed. A few are cut short so that the
    // next header lands mid-frame, and now and then stray bytes go in
    // between frames instead.
    task automatic send_frame();
        int                pick;
        int                len;
        int                cut;
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] len_byte;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] skew;
        logic [BYTE_W-1:0] data;
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(255)));
            return;
        end

        pick = $urandom_range(9);
        if (pick < 3)
            id = parser_cfg.sign_frame_id;
        else if (pick < 6)
            id = parser_cfg.alive_frame_id;
        else
            id = BYTE_W'($urandom_range(255));
        id = avoid_header(id);

        // mostly short payloads; the odd long one, and the full length
        pick = $urandom_range(199);
        if (pick == 0)
            len_byte = 8'd255;
        else if (pick < 4)
            len_byte = BYTE_W'($urandom_range(254, 9));
        else
            len_byte = BYTE_W'($urandom_range(8));
        len_byte = avoid_header(len_byte);
        len      = int'(len_byte);

        cut = ($urandom_range(99) < 8) ? int'($urandom_range(len + 2)) : -1;
        sum = '0;
        send_byte(parser_cfg.header_byte);
        for (int n = 0; n < len + 3; n++)
        begin
            if (n == cut)
                return;
            if (n == 0)
                send_byte(id);
            else if (n == 1)
                send_byte(len_byte);
            else if (n < len + 2)
            begin
                data = avoid_header(BYTE_W'($urandom_range(255)));
                sum  = sum + data;
                send_byte(data);
            end
            else
            begin
                // a bad checksum now and then
                skew = ($urandom_range(99) < 85) ? 8'd0 : BYTE_W'($urandom_range(1, 255));
                send_byte(sum + skew);
            end
        end
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] sign,
                             input logic [BYTE_W-1:0] alive, input logic [BYTE_W-1:0] ival,
                             input int src_pct, input int snk_pct, input bit long_hold);
        int  start;
        bit  hold_asked;
        release_input();
        drain();
        apply_settings(hdr, sign, alive, ival);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        start        = sent_count;
        hold_asked   = 1'b0;
        while (sent_count - start < PHASE_BYTES)
        begin
            if (long_hold && !hold_asked && sent_count - start >= 40)
            begin
                holds_requested++;
                hold_asked = 1'b1;
            end
            send_frame();
        end
    endtask

    task automatic add_row(input logic [BYTE_W-1:0] b, input bit fixed = 1'b0,
                           input result_t typed = '0);
        stim_row_t row;
        row.rx      = b;
        row.fixed   = fixed;
        row.verdict = typed;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        in_valid  = 1'b0;
        rx_byte   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        reset_parser();

        // sender idles a little, receiver a lot
        src_idle_pct = 22;
        snk_idle_pct = 83;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, register values as after reset.
        // Stray byte before any header: drop it.
        add_row(8'h00);
        // Zero length, checksum zero; selector still at its reset value
        add_row(8'hff);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h00, 1'b1, {1'b1, 8'h00, 8'h00, 1'b0, SEL_START, 1'b0, 1'b0});
        // Sign frame, top data value: selector moves on to two
        add_row(8'hff);
        add_row(8'hed);
        add_row(8'h01);
        add_row(8'hfe);
        add_row(8'hfe, 1'b1, {1'b1, 8'hed, 8'h01, 1'b1, SEL_LOW, 1'b0, 1'b0});
        // Alive frame with a checksum that misses: no flags, selector held
        add_row(8'hff);
        add_row(8'h1c);
        add_row(8'h02);
        add_row(8'hfe);
        add_row(8'h03);
        add_row(8'h00, 1'b1, {1'b0, 8'h1c, 8'h02, 1'b0, SEL_LOW, 1'b0, 1'b0});
        // Header in the length slot restarts; then an alive frame whose sum wraps
        add_row(8'hff);
        add_row(8'h1c);
        add_row(8'hff);
        add_row(8'h1c);
        add_row(8'h02);
        add_row(8'hfe);
        add_row(8'h03);
        add_row(8'h01);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].fixed, directed_rows[i].verdict);

        // Random part. Alive count is never cleared by a register write, so
        // the large interval lets it build up and the small one after it is
        // already passed.
        run_phase(8'ha5, 8'h00, 8'h01, 8'd3,   22, 83, 1'b0);
        // sign and alive share an ID: sign must win
        run_phase(8'h00, 8'hff, 8'hff, 8'd1,   22, 83, 1'b0);
        run_phase(8'hff, 8'h10, 8'h00, 8'd255, 83, 22, 1'b0);
        run_phase(8'h7e, 8'h42, 8'h43, 8'd200, 83, 22, 1'b0);
        // lowered interval, with a long receiver hold-off while bytes keep coming
        run_phase(8'h55, 8'h80, 8'h81, 8'd2,   0,  0,  1'b1);
        // interval of zero: every good alive frame is a milestone
        run_phase(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                  BYTE_W'($urandom_range(255)), 8'd0, 0, 0, 1'b0);

        release_input();
        drain();

        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("tb_length_framed_packet_checker: PASS");
        else
            $display("tb_length_framed_packet_checker: FAIL");
        $finish;
    end

    // Give up well beyond the slowest legal run
    initial
    begin
        #5ms;
        $display("tb_length_framed_packet_checker: FAIL");
        $finish;
    end

endmodule
